[hdl/bss_pkg.sv]
// shared types and constants for the bit-packed sorted search block
// no dependencies; used by bss_front, bss_back and bitpacked_sorted_search
package bss_pkg;

  // field and register widths
  localparam int KW_W       = 6;
  localparam int CNT_W      = 11;
  localparam int POS_W      = 12;
  localparam int ADDR_W     = 13;
  localparam int BYTE_W     = 8;
  localparam int KEY_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // key bit address: index below 2048 times width of at most 32
  localparam int BIT_W      = 17;
  // byte address of one window byte: bit address / 8 plus window offset
  localparam int BADDR_W    = BIT_W - 3 + 1;
  // a key of up to 32 bits at any bit offset spans at most five bytes
  localparam int WIN_BYTES  = 5;
  localparam int WIN_W      = WIN_BYTES * BYTE_W;
  localparam int WIN_CNT_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd1;

  // register reset values and limits
  localparam logic [KW_W-1:0]  KW_RESET  = 6'd8;
  localparam logic [KW_W-1:0]  KW_MIN    = 6'd1;
  localparam logic [KW_W-1:0]  KW_MAX    = 6'd32;
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1;
  localparam logic [CNT_W-1:0] CNT_MIN   = 11'd1;

  // position reported when equal mode finds nothing
  localparam logic [POS_W-1:0] POS_NONE  = '1;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_EQUAL   = 2'd1,
    FUNC_LOWER   = 2'd2,
    FUNC_SECTION = 2'd3
  } bss_func_e;

  // one classified beat held in the queue between front and back
  typedef struct packed {
    bss_func_e               func;
    logic                    store_ok;  // load address lies inside the store
    logic                    over;      // target above the all-ones key
    logic [ADDR_W-1:0]       addr;
    logic [BYTE_W-1:0]       data;
    logic [KEY_W-1:0]        target;
  } bss_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_FETCH,
    ST_CMP,
    ST_OUT
  } bss_state_e;

endpackage

[hdl/bss_front.sv]
// front end: accepts input beats, classifies them and queues them
// depends on bss_pkg
module bss_front #(
  parameter int STORE_BYTES = 8192
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   in_func_i,
  input  logic [bss_pkg::ADDR_W-1:0]   in_byte_address_i,
  input  logic [bss_pkg::BYTE_W-1:0]   in_byte_value_i,
  input  logic [bss_pkg::KEY_W-1:0]    in_target_i,
  input  logic [bss_pkg::KW_W-1:0]     key_width_i,
  output logic                         cmd_valid_o,
  output bss_pkg::bss_cmd_t            cmd_o,
  input  logic                         cmd_pop_i
);

  localparam int DEPTH = 2;

  bss_pkg::bss_cmd_t ent_q [DEPTH];
  bss_pkg::bss_cmd_t new_cmd;
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push, pop;
  logic [31:0]       addr_ext;

  // classify the incoming beat
  always_comb begin
    addr_ext         = 32'(in_byte_address_i);
    new_cmd.func     = bss_pkg::bss_func_e'(in_func_i);
    new_cmd.store_ok = addr_ext < 32'(STORE_BYTES);
    new_cmd.over     = (key_width_i != bss_pkg::KW_MAX) &&
                       ((in_target_i >> key_width_i) != '0);
    new_cmd.addr     = in_byte_address_i;
    new_cmd.data     = in_byte_value_i;
    new_cmd.target   = in_target_i;
  end

  assign in_stall_o  = (cnt_q == 2'(DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_ptr_q];

  // queue pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

[hdl/bss_back.sv]
// back end: packed key store, binary search sequencer and result register
// depends on bss_pkg
module bss_back #(
  parameter int STORE_BYTES = 8192
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bss_pkg::KW_W-1:0]     key_width_i,
  input  logic [bss_pkg::CNT_W-1:0]    entry_count_i,
  input  logic                         cmd_valid_i,
  input  bss_pkg::bss_cmd_t            cmd_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bss_pkg::POS_W-1:0]    out_position_o
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  // packed store
  logic [bss_pkg::BYTE_W-1:0] store_q [STORE_BYTES];
  logic [bss_pkg::BYTE_W-1:0] rd_data_q;
  logic                       we, re;
  logic [AW-1:0]              waddr, raddr;
  logic [31:0]                waddr_ext, raddr_ext;

  bss_pkg::bss_state_e          state_q, state_d;
  bss_pkg::bss_func_e           func_q, func_d;
  logic [bss_pkg::KEY_W-1:0]    target_q, target_d;
  logic [bss_pkg::CNT_W-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [bss_pkg::BIT_W-1:0]    bit_q, bit_d;
  logic [bss_pkg::WIN_CNT_W-1:0] k_q, k_d, rd_k_q, rd_k_d;
  logic                         rd_pend_q, rd_pend_d, rd_ok_q, rd_ok_d;
  logic [bss_pkg::WIN_W-1:0]    win_q, win_d;
  logic [bss_pkg::POS_W-1:0]    res_q, res_d;
  logic                         out_valid_q, out_valid_d;
  logic [bss_pkg::POS_W-1:0]    out_pos_q, out_pos_d;

  logic [bss_pkg::CNT_W:0]      mid_sum;
  logic [bss_pkg::BADDR_W-1:0]  byte_k;
  logic [bss_pkg::KEY_W-1:0]    key, key_mask;
  logic                         round_up;

  assign waddr_ext = 32'(cmd_i.addr);
  assign waddr     = waddr_ext[AW-1:0];
  assign byte_k    = {1'b0, bit_q[bss_pkg::BIT_W-1:3]} + bss_pkg::BADDR_W'(k_q);
  assign raddr_ext = 32'(byte_k);
  assign raddr     = raddr_ext[AW-1:0];

  // midpoint rounds up in equal and section modes
  assign round_up  = (func_q != bss_pkg::FUNC_LOWER);
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} + (bss_pkg::CNT_W + 1)'(round_up);

  // key extraction from the five-byte window
  assign key_mask  = bss_pkg::KEY_W'((33'd1 << key_width_i) - 33'd1);
  assign key       = bss_pkg::KEY_W'(win_q >> bit_q[2:0]) & key_mask;

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    target_d    = target_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    bit_d       = bit_q;
    k_d         = k_q;
    rd_k_d      = rd_k_q;
    rd_pend_d   = 1'b0;
    rd_ok_d     = rd_ok_q;
    res_d       = res_q;
    win_d       = win_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_pos_d   = out_pos_q;

    // collect the byte read in the previous cycle
    if (rd_pend_q) begin
      win_d[{rd_k_q, 3'b000} +: bss_pkg::BYTE_W] = rd_ok_q ? rd_data_q : '0;
    end

    unique case (state_q)
      bss_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          func_d    = cmd_i.func;
          target_d  = cmd_i.target;
          lo_d      = '0;
          hi_d      = (cmd_i.func == bss_pkg::FUNC_LOWER) ? entry_count_i
                                                          : entry_count_i - 1'b1;
          if (cmd_i.func == bss_pkg::FUNC_LOAD) begin
            we = cmd_i.store_ok;
          end else if (cmd_i.over && cmd_i.func != bss_pkg::FUNC_EQUAL) begin
            // target above every possible key
            res_d   = bss_pkg::POS_W'(hi_d);
            state_d = bss_pkg::ST_OUT;
          end else begin
            state_d = bss_pkg::ST_CHECK;
          end
        end
      end
      bss_pkg::ST_CHECK: begin
        if ((func_q == bss_pkg::FUNC_EQUAL) ? (lo_q <= hi_q) : (lo_q < hi_q)) begin
          mid_d   = mid_sum[bss_pkg::CNT_W:1];
          state_d = bss_pkg::ST_MUL;
        end else begin
          res_d   = (func_q == bss_pkg::FUNC_EQUAL) ? bss_pkg::POS_NONE
                                                    : bss_pkg::POS_W'(lo_q);
          state_d = bss_pkg::ST_OUT;
        end
      end
      bss_pkg::ST_MUL: begin
        bit_d   = bss_pkg::BIT_W'(mid_q) * bss_pkg::BIT_W'(key_width_i);
        k_d     = '0;
        state_d = bss_pkg::ST_FETCH;
      end
      bss_pkg::ST_FETCH: begin
        // one window byte read per cycle, the read data is registered by the store
        if (k_q < bss_pkg::WIN_CNT_W'(bss_pkg::WIN_BYTES)) begin
          re        = 1'b1;
          rd_pend_d = 1'b1;
          rd_k_d    = k_q;
          rd_ok_d   = raddr_ext < 32'(STORE_BYTES);
          k_d       = k_q + 1'b1;
        end else begin
          state_d   = bss_pkg::ST_CMP;
        end
      end
      bss_pkg::ST_CMP: begin
        state_d = bss_pkg::ST_CHECK;
        unique case (func_q)
          bss_pkg::FUNC_EQUAL: begin
            if (key == target_q) begin
              res_d   = bss_pkg::POS_W'(mid_q);
              state_d = bss_pkg::ST_OUT;
            end else if (key > target_q) begin
              if (mid_q == '0) begin
                // range empties without wrapping the end index
                res_d   = bss_pkg::POS_NONE;
                state_d = bss_pkg::ST_OUT;
              end else begin
                hi_d = mid_q - 1'b1;
              end
            end else begin
              lo_d = mid_q + 1'b1;
            end
          end
          bss_pkg::FUNC_LOWER: begin
            if (key >= target_q) hi_d = mid_q;
            else                 lo_d = mid_q + 1'b1;
          end
          bss_pkg::FUNC_SECTION: begin
            if (key <= target_q) lo_d = mid_q;
            else                 hi_d = mid_q - 1'b1;
          end
          default: state_d = bss_pkg::ST_IDLE;
        endcase
      end
      bss_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_pos_d   = res_q;
          state_d     = bss_pkg::ST_IDLE;
        end
      end
      default: state_d = bss_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bss_pkg::ST_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    target_q  <= target_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    bit_q     <= bit_d;
    k_q       <= k_d;
    rd_k_q    <= rd_k_d;
    rd_ok_q   <= rd_ok_d;
    win_q     <= win_d;
    res_q     <= res_d;
    out_pos_q <= out_pos_d;
  end

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= cmd_i.data;
    end
    if (re) begin
      rd_data_q <= store_q[raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_position_o = out_pos_q;

endmodule

[hdl/bitpacked_sorted_search.sv]
// Binary search over a sorted, bit-packed key store loaded byte by byte.
// Input channel (in_valid_i / in_stall_o): one beat per load or query; a load
// beat (func 0) writes one store byte, a query beat (equal, lower-bound,
// section) gives exactly one position beat on the output channel
// (out_valid_o / out_stall_i), -1 when equal mode finds no match.
// A two-beat queue sits between the front and the search sequencer.
// Configuration (cfg_valid_i / cfg_ready_o, always ready): index 0 key width,
// index 1 entry count; the user must write them only while the block is idle,
// as the block itself does not enforce this. A load is written to the store
// straight from the idle state. A query runs p probes (p at most about
// log2(entry_count)+1); a probe is a range check, a multiply, five store reads,
// a drain step and a compare, and a final range check ends the search. An
// equal-mode hit skips that check; a target above the width's all-ones key skips
// the probes in lower-bound and section modes. One query runs at a time.
// Reset clears the queue, the sequencer and the output valid, and sets key
// width 8 and entry count 1; store contents are undefined until loaded.
// When the receiver stalls, the result holds, the sequencer waits with the
// next result, and the input stalls once the queue holds two beats.
// depends on bss_pkg, bss_front and bss_back
module bitpacked_sorted_search #(
  parameter int MAX_ENTRIES = 1024,
  parameter int STORE_BYTES = 8192
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     in_func_i,
  input  logic [bss_pkg::ADDR_W-1:0]     in_byte_address_i,
  input  logic [bss_pkg::BYTE_W-1:0]     in_byte_value_i,
  input  logic [bss_pkg::KEY_W-1:0]      in_target_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bss_pkg::POS_W-1:0]      out_position_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bss_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [bss_pkg::KW_W-1:0]  key_width_q, key_width_d, eff_width;
  logic [bss_pkg::CNT_W-1:0] entry_count_q, entry_count_d, eff_count;
  logic                      cmd_valid, cmd_pop;
  bss_pkg::bss_cmd_t         cmd;

  assign cfg_ready_o = 1'b1;

  // configuration register writes
  always_comb begin
    key_width_d   = key_width_q;
    entry_count_d = entry_count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == bss_pkg::CFG_KEY_WIDTH) begin
        key_width_d = cfg_data_i[bss_pkg::KW_W-1:0];
      end else if (cfg_index_i == bss_pkg::CFG_ENTRY_COUNT) begin
        entry_count_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_width_q   <= bss_pkg::KW_RESET;
      entry_count_q <= bss_pkg::CNT_RESET;
    end else begin
      key_width_q   <= key_width_d;
      entry_count_q <= entry_count_d;
    end
  end

  // clamp registers into their working ranges
  always_comb begin
    priority if (key_width_q == '0)             eff_width = bss_pkg::KW_MIN;
    else if (key_width_q > bss_pkg::KW_MAX)     eff_width = bss_pkg::KW_MAX;
    else                                        eff_width = key_width_q;

    priority if (entry_count_q == '0)                 eff_count = bss_pkg::CNT_MIN;
    else if (32'(entry_count_q) > 32'(MAX_ENTRIES))   eff_count = bss_pkg::CNT_W'(MAX_ENTRIES);
    else                                              eff_count = entry_count_q;
  end

  bss_front #(
    .STORE_BYTES (STORE_BYTES)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_func_i         (in_func_i),
    .in_byte_address_i (in_byte_address_i),
    .in_byte_value_i   (in_byte_value_i),
    .in_target_i       (in_target_i),
    .key_width_i       (eff_width),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_pop_i         (cmd_pop)
  );

  bss_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_width_i    (eff_width),
    .entry_count_i  (eff_count),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_position_o (out_position_o)
  );

  // the sequencer only takes a beat the queue holds
  a_pop_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("queue popped while empty");

  // after an accepted input beat the queue holds a beat in the next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> cmd_valid)
    else $error("accepted beat missing from queue");

  // a result is -1 or lies within 0 .. entry count
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_position_o == bss_pkg::POS_NONE) ||
                    (out_position_o <= bss_pkg::POS_W'(eff_count)))
    else $error("position out of range");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// testbench for bitpacked_sorted_search: packs sorted keys into the store and
// checks every equal, lower-bound and section search result; depends on bss_pkg
module tb_top;
  import bss_pkg::*;

  localparam int MAX_ENTRIES    = 1024;
  localparam int STORE_BYTES    = 8192;
  localparam int DRAIN_CYCLES   = 16;
  localparam int END_CYCLES     = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLDOFF_CYCLES = 300;

  // indexes outside the register map, written to see that they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    bss_func_e          func;
    logic [KEY_W-1:0]   target;
    logic [POS_W-1:0]   position;
  } search_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            in_func_i;
  logic [ADDR_W-1:0]     in_byte_address_i;
  logic [BYTE_W-1:0]     in_byte_value_i;
  logic [KEY_W-1:0]      in_target_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [POS_W-1:0]      out_position_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predictor state: store image and register copies
  logic [BYTE_W-1:0]     store_img [STORE_BYTES];
  logic [KW_W-1:0]       kw_reg;
  logic [CNT_W-1:0]      cnt_reg;

  // keys of the current phase and the byte image built from them
  logic [KEY_W-1:0]      key_list [MAX_ENTRIES];
  logic [BYTE_W-1:0]     packed_image [STORE_BYTES];

  search_result_t        expected_positions [$];
  search_result_t        head_result;
  int                    mismatch_count;
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  int                    rx_hold_left;
  int                    idle_cycles;

  bitpacked_sorted_search #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .STORE_BYTES(STORE_BYTES)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_func_i        (in_func_i),
    .in_byte_address_i(in_byte_address_i),
    .in_byte_value_i  (in_byte_value_i),
    .in_target_i      (in_target_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_position_o   (out_position_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // effective register values, out-of-range settings clamp
  function automatic int eff_width();
    if (kw_reg < KW_MIN) return KW_MIN;
    if (kw_reg > KW_MAX) return KW_MAX;
    return kw_reg;
  endfunction

  function automatic int eff_count();
    if (cnt_reg < CNT_MIN) return CNT_MIN;
    if (cnt_reg > MAX_ENTRIES) return MAX_ENTRIES;
    return cnt_reg;
  endfunction

  function automatic logic [KEY_W-1:0] mask_of(int w);
    return KEY_W'((64'd1 << w) - 64'd1);
  endfunction

  // key idx of width w, read through a five-byte window, bits past the store are 0
  function automatic logic [KEY_W-1:0] key_at(int idx, int w);
    int bit_pos;
    int first_byte;
    int offset;
    logic [WIN_W-1:0] window;
    bit_pos    = idx * w;
    first_byte = bit_pos >> 3;
    offset     = bit_pos & 7;
    window     = '0;
    for (int k = 0; k < WIN_BYTES; k++) begin
      if (first_byte + k < STORE_BYTES) window[8*k +: 8] = store_img[first_byte + k];
    end
    return KEY_W'(window >> offset) & mask_of(w);
  endfunction

  // binary search in the three query modes
  function automatic logic [POS_W-1:0] search_position(bss_func_e f, logic [KEY_W-1:0] t);
    int w;
    int n;
    int lo;
    int hi;
    int mid;
    int pos;
    logic [KEY_W-1:0] k;
    w   = eff_width();
    n   = eff_count();
    pos = -1;
    case (f)
      FUNC_EQUAL: begin
        lo = 0;
        hi = n - 1;
        while (lo <= hi && pos < 0) begin
          mid = (lo + hi + 1) / 2;
          k   = key_at(mid, w);
          if (k == t) pos = mid;
          else if (k > t) hi = mid - 1;
          else lo = mid + 1;
        end
      end
      FUNC_LOWER: begin
        if (t > mask_of(w)) begin
          pos = n;
        end else begin
          lo = 0;
          hi = n;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (key_at(mid, w) >= t) hi = mid;
            else lo = mid + 1;
          end
          pos = lo;
        end
      end
      FUNC_SECTION: begin
        if (t > mask_of(w)) begin
          pos = n - 1;
        end else begin
          lo = 0;
          hi = n - 1;
          while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (key_at(mid, w) <= t) lo = mid;
            else hi = mid - 1;
          end
          pos = lo;
        end
      end
      default: pos = -1;
    endcase
    return POS_W'(pos);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, what);
  endtask

  // one input beat, with random sender gaps; prediction at acceptance
  task automatic send_beat(input bss_func_e f, input logic [ADDR_W-1:0] a,
                           input logic [BYTE_W-1:0] d, input logic [KEY_W-1:0] t);
    search_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_func_i         <= f;
    in_byte_address_i <= a;
    in_byte_value_i   <= d;
    in_target_i       <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (f == FUNC_LOAD) begin
      store_img[a] = d;
    end else begin
      res.func     = f;
      res.target   = t;
      res.position = search_position(f, t);
      expected_positions = {expected_positions, res};
    end
  endtask

  task automatic query(input bss_func_e f, input logic [KEY_W-1:0] t);
    send_beat(f, ADDR_W'($urandom), BYTE_W'($urandom), t);
  endtask

  // lower valid, wait for every result, then let trailing loads retire
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_KEY_WIDTH:   kw_reg = data[KW_W-1:0];
      CFG_ENTRY_COUNT: cnt_reg = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] kw_data,
                           input logic [CFG_DATA_W-1:0] cnt_data, input bit with_spare);
    wait_idle();
    if (with_spare) begin
      write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
      write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
    end
    write_reg(CFG_KEY_WIDTH, kw_data);
    write_reg(CFG_ENTRY_COUNT, cnt_data);
    cfg_valid_i <= 1'b0;
  endtask

  // ascending keys with duplicates, spread over the width's range
  task automatic gen_sorted_keys();
    int n;
    logic [63:0] lim;
    logic [63:0] cur;
    logic [63:0] stride;
    n      = eff_count();
    lim    = mask_of(eff_width());
    stride = lim / n * 2 + 1;
    if (stride > 64'hFFFF_FFFF) stride = 64'hFFFF_FFFF;
    cur = $urandom_range(32'(lim >> 2), 0);
    for (int i = 0; i < n; i++) begin
      key_list[i] = cur[KEY_W-1:0];
      if ($urandom_range(3) != 0) cur += $urandom_range(32'(stride), 1);
      if (cur > lim) cur = lim;
    end
  endtask

  // pack key_list and load every byte a search window can touch
  task automatic load_keys();
    int w;
    int n;
    int last;
    int bit_pos;
    w    = eff_width();
    n    = eff_count();
    last = (((n - 1) * w) >> 3) + WIN_BYTES - 1;
    if (last >= STORE_BYTES) last = STORE_BYTES - 1;
    for (int a = 0; a <= last; a++) packed_image[a] = '0;
    for (int i = 0; i < n; i++) begin
      for (int b = 0; b < w; b++) begin
        bit_pos = i * w + b;
        packed_image[bit_pos >> 3][bit_pos & 7] = key_list[i][b];
      end
    end
    for (int a = 0; a <= last; a++) begin
      send_beat(FUNC_LOAD, ADDR_W'(a), packed_image[a], KEY_W'($urandom));
    end
  endtask

  // mostly searches near stored keys, some stray loads anywhere in the store
  task automatic random_query();
    int r;
    int pick;
    logic [KEY_W-1:0] lim;
    logic [KEY_W-1:0] t;
    bss_func_e f;
    r    = $urandom_range(99);
    lim  = mask_of(eff_width());
    pick = $urandom_range(eff_count() - 1, 0);
    f    = bss_func_e'(2'($urandom_range(3, 1)));
    if (r < 10) begin
      send_beat(FUNC_LOAD, ADDR_W'($urandom), BYTE_W'($urandom), KEY_W'($urandom));
    end else begin
      if (r < 60) t = key_list[pick] + KEY_W'($urandom_range(2, 0)) - 1'b1;
      else if (r < 75) t = $urandom_range(lim, 0);
      else if (r < 85 && lim != '1) t = $urandom_range(32'hFFFF_FFFF, lim + 1'b1);
      else t = $urandom();
      query(f, t);
    end
  endtask

  // reset values: width 8, one entry
  task automatic test_reset_values();
    key_list[0] = 32'h80;
    load_keys();
    query(FUNC_EQUAL, 32'h80);
    query(FUNC_EQUAL, 32'h7F);
    query(FUNC_LOWER, 32'h100);
    query(FUNC_LOWER, 32'h81);
    query(FUNC_LOWER, 32'h0);
    query(FUNC_SECTION, 32'h7F);
    query(FUNC_SECTION, 32'hFFFF_FFFF);
  endtask

  // every mode on a small array with duplicates and a key one below all-ones
  task automatic test_directed_modes();
    logic [KEY_W-1:0] dir_keys [7];
    dir_keys = '{32'd2, 32'd5, 32'd5, 32'd5, 32'd100, 32'd4093, 32'd4094};
    configure(11'd12, 11'd7, 1'b0);
    for (int i = 0; i < 7; i++) key_list[i] = dir_keys[i];
    load_keys();
    // address and data extremes, outside any search window
    send_beat(FUNC_LOAD, 13'h1FFF, 8'hFF, 32'hFFFF_FFFF);
    send_beat(FUNC_LOAD, 13'h1FFE, 8'h00, 32'h0);
    query(FUNC_EQUAL, 32'd5);
    query(FUNC_EQUAL, 32'd3);
    query(FUNC_EQUAL, 32'd2);
    query(FUNC_EQUAL, 32'd4094);
    query(FUNC_EQUAL, 32'hFFFF_FFFF);
    query(FUNC_LOWER, 32'd0);
    query(FUNC_LOWER, 32'd5);
    query(FUNC_LOWER, 32'd101);
    // no key qualifies, then target past the width's maximum
    query(FUNC_LOWER, 32'd4095);
    query(FUNC_LOWER, 32'd4096);
    // every key above target
    query(FUNC_SECTION, 32'd1);
    query(FUNC_SECTION, 32'd99);
    query(FUNC_SECTION, 32'd4094);
    query(FUNC_SECTION, 32'h8000_0000);
  endtask

  // width and count at and beyond their limits, spare register indexes
  task automatic test_register_limits();
    int split;
    configure(11'd0, 11'd0, 1'b1);
    key_list[0] = 32'd1;
    load_keys();
    query(FUNC_EQUAL, 32'd1);
    query(FUNC_EQUAL, 32'd0);
    query(FUNC_LOWER, 32'd2);
    query(FUNC_SECTION, 32'd0);
    query(FUNC_SECTION, 32'd7);

    configure(11'd33, 11'd3, 1'b0);
    key_list[0] = 32'd1;
    key_list[1] = 32'h8000_0000;
    key_list[2] = 32'hFFFF_FFFF;
    load_keys();
    query(FUNC_EQUAL, 32'hFFFF_FFFF);
    query(FUNC_LOWER, 32'h8000_0001);
    query(FUNC_LOWER, 32'd0);
    query(FUNC_SECTION, 32'h7FFF_FFFF);

    // one-bit keys, a run of zeros then ones; count past its limit clamps to full
    configure(11'd1, 11'h7FF, 1'b0);
    split = $urandom_range(700, 300);
    for (int i = 0; i < MAX_ENTRIES; i++) key_list[i] = (i >= split) ? 32'd1 : 32'd0;
    load_keys();
    query(FUNC_LOWER, 32'd1);
    query(FUNC_LOWER, 32'd0);
    query(FUNC_LOWER, 32'd2);
    query(FUNC_SECTION, 32'd0);
    query(FUNC_SECTION, 32'd1);
    query(FUNC_EQUAL, 32'd1);
    query(FUNC_EQUAL, 32'd0);
    query(FUNC_EQUAL, 32'd2);
  endtask

  // random widths and counts, mostly small arrays
  task automatic test_random_searches(input int tx_pct, input int rx_pct,
                                      input int phases, input int queries);
    int r;
    int kw;
    int cnt;
    logic [CFG_DATA_W-1:0] kw_data;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (phases) begin
      r = $urandom_range(9);
      if (r == 0) kw = 0;
      else if (r == 1) kw = $urandom_range(63, 33);
      else kw = $urandom_range(32, 1);
      kw_data = CFG_DATA_W'(kw);
      // unused upper data bits now and then
      if ($urandom_range(3) == 0) kw_data[CFG_DATA_W-1:KW_W] = (CFG_DATA_W - KW_W)'($urandom());
      r = $urandom_range(9);
      if (r == 0) cnt = $urandom_range(64, 25);
      else if (r == 1) cnt = 0;
      else cnt = $urandom_range(24, 1);
      configure(kw_data, CFG_DATA_W'(cnt), 1'b0);
      gen_sorted_keys();
      load_keys();
      repeat (queries) random_query();
    end
  endtask

  // receiver holds off while queries keep coming, so the input backs up
  task automatic test_output_holdoff();
    configure(11'd8, 11'd40, 1'b0);
    gen_sorted_keys();
    load_keys();
    rx_hold_left = HOLDOFF_CYCLES;
    repeat (20) random_query();
  endtask

  // receiver stall, random or a counted hold-off
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // compare each position beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_positions.size() == 0) begin
        report_mismatch($sformatf("position %0d with no search pending",
                                  $signed(out_position_o)));
      end else begin
        head_result = expected_positions.pop_front();
        if (out_position_o !== head_result.position) begin
          report_mismatch($sformatf("func %0d target %h: expected %0d, got %0d",
                                    head_result.func, head_result.target,
                                    $signed(head_result.position),
                                    $signed(out_position_o)));
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    in_func_i         = FUNC_LOAD;
    in_byte_address_i = '0;
    in_byte_value_i   = '0;
    in_target_i       = '0;
    out_stall_i       = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CFG_KEY_WIDTH;
    cfg_data_i        = '0;
    kw_reg            = KW_RESET;
    cnt_reg           = CNT_RESET;
    mismatch_count    = 0;
    rx_hold_left      = 0;
    idle_cycles       = 0;
    tx_idle_pct       = 6;
    rx_idle_pct       = 47;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_directed_modes();
    test_register_limits();
    test_random_searches(6, 47, 1, 20);
    test_random_searches(47, 6, 1, 20);
    test_random_searches(0, 0, 1, 20);
    test_output_holdoff();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_positions.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bss_pkg.sv
hdl/bss_front.sv
hdl/bss_back.sv
hdl/bitpacked_sorted_search.sv
tb/tb_top.sv
